// ===== rtl/core/accumulator_cpu_execute_core_defines.svh =====
// Assertion macros shared by the execute core RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ACCUMULATOR_CPU_EXECUTE_CORE_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during rst.
`define ACPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ACPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ACPU_ASSERT_NOW(lbl, ante, cons, msg)
`define ACPU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/acpu_pkg.sv =====
// Shared types, widths and opcodes of the accumulator execute core.
// No dependencies; the execute core, memory and ALU files import this package.
`timescale 1ns / 1ps

package acpu_pkg;

  localparam int DATA_W    = 16;
  localparam int ADDR_W    = 12;
  localparam int OP_W      = 4;
  localparam int SHAMT_W   = 5;
  localparam int SH_IDX_W  = $clog2(DATA_W);
  localparam int MEM_DEPTH_DEFAULT = 4096;

  localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
  localparam logic [OP_W-1:0] OP_STORE  = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd3;
  localparam logic [OP_W-1:0] OP_INPUT  = 4'd4;
  localparam logic [OP_W-1:0] OP_OUTPUT = 4'd5;
  localparam logic [OP_W-1:0] OP_SKIP   = 4'd6;
  localparam logic [OP_W-1:0] OP_JUMP   = 4'd7;
  localparam logic [OP_W-1:0] OP_SHR    = 4'd8;
  localparam logic [OP_W-1:0] OP_SHL    = 4'd9;
  localparam logic [OP_W-1:0] OP_JZ     = 4'd10;
  localparam logic [OP_W-1:0] OP_JNZ    = 4'd11;
  localparam logic [OP_W-1:0] OP_CLEAR  = 4'd12;
  localparam logic [OP_W-1:0] OP_INVERT = 4'd13;
  localparam logic [OP_W-1:0] OP_PCDEC  = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] data_value;
    logic [SHAMT_W-1:0]       shift_count;
  } instr_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_value;
    logic [ADDR_W-1:0]        pc_value;
    logic                     out_valid;
    logic signed [DATA_W-1:0] out_word;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] acc_next;
    logic [ADDR_W-1:0] pc_next;
    logic              store_en;
    result_t           res;
  } alu_out_t;

endpackage

// ===== rtl/core/accumulator_cpu_execute_core.sv =====
// Execute stage of a 16-bit accumulator machine: pipeline, state and result register.
// Depends on acpu_pkg, acpu_mem, acpu_alu and the assertion macro header.
`timescale 1ns / 1ps
`include "accumulator_cpu_execute_core_defines.svh"

// Usage:
// - instr carries one decoded instruction; it is taken on a rising edge with
//   instr_valid high and instr_stall low.
// - result carries the accumulator and PC after that instruction, plus the
//   output flag and word; it is taken with result_valid high and result_stall low.
// - Every instruction gives exactly one result, in order.
// - A result passes the stage 1 register (address fold), the stage 2 register with the
//   memory read, execute and the result register before it shows on result_valid.
// - Throughput: one instruction per cycle while result_stall is low. The accumulator
//   and PC update in the execute stage, and a load reads the memory's one read port
//   one stage ahead, with a bypass for a store executing at the same edge.
// - A stalled result holds in its register; the pipeline keeps filling until both
//   stages are full, then raises instr_stall.
// - Synchronous reset rst clears the accumulator, the PC and all valid flags.
//   Memory is not cleared; loading a word never stored returns unspecified data.
// - An address at or beyond MEM_DEPTH wraps modulo MEM_DEPTH.

module accumulator_cpu_execute_core #(
  parameter int MEM_DEPTH = acpu_pkg::MEM_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              instr_valid,
  output logic              instr_stall,
  input  acpu_pkg::instr_t  instr,
  output logic              result_valid,
  input  logic              result_stall,
  output acpu_pkg::result_t result
);
  import acpu_pkg::*;

  localparam int IDX_W  = $clog2(MEM_DEPTH);
  localparam int FRAC_W = 2 * ADDR_W;
  localparam bit WRAP   = (MEM_DEPTH < (1 << ADDR_W));
  // Fixed-point reciprocal: remainder = (frac(addr * MOD_MUL) * MEM_DEPTH) >> FRAC_W
  localparam logic [FRAC_W-1:0] MOD_MUL =
    FRAC_W'(((64'd1 << FRAC_W) - 64'd1) / MEM_DEPTH + 64'd1);
  localparam logic [IDX_W:0] DEPTH_V = (IDX_W + 1)'(MEM_DEPTH);

  // Stage 1: instruction and reciprocal product
  logic              s1_valid;
  instr_t            s1_instr;
  logic [FRAC_W-1:0] s1_frac;
  logic [IDX_W-1:0]  s1_idx;

  // Stage 2: execute
  logic              s2_valid;
  instr_t            s2_instr;
  logic [IDX_W-1:0]  s2_idx;
  logic              fwd_hit;
  logic [DATA_W-1:0] fwd_data;

  logic [DATA_W-1:0] ac;
  logic [ADDR_W-1:0] pc;

  logic [FRAC_W+ADDR_W-1:0] prod_in;
  logic [FRAC_W+IDX_W:0]    prod_idx;
  logic [DATA_W-1:0]        rd_data;
  logic [DATA_W-1:0]        mem_word;
  logic                     in_fire;
  logic                     adv1;
  logic                     s2_fire;
  logic                     s2_pc_op;
  alu_out_t                 alu_out;

  assign s2_fire     = s2_valid && (!result_valid || !result_stall);
  assign adv1        = s1_valid && (!s2_valid || s2_fire);
  assign instr_stall = s1_valid && !adv1;
  assign in_fire     = instr_valid && !instr_stall;

  assign prod_in  = {{FRAC_W{1'b0}}, instr.address} * {{ADDR_W{1'b0}}, MOD_MUL};
  assign prod_idx = {{(IDX_W + 1){1'b0}}, s1_frac} * {{FRAC_W{1'b0}}, DEPTH_V};

  always_comb begin
    if (WRAP) begin
      s1_idx = prod_idx[FRAC_W +: IDX_W];
    end else begin
      s1_idx = IDX_W'(s1_instr.address);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_instr <= instr;
      s1_frac  <= prod_in[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv1) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
    if (adv1) begin
      s2_instr <= s1_instr;
      s2_idx   <= s1_idx;
      // catch a store that lands at the same edge as this read
      fwd_hit  <= s2_fire && alu_out.store_en && (s2_idx == s1_idx);
      fwd_data <= ac;
    end
  end

  acpu_mem #(
    .DEPTH (MEM_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (s2_fire && alu_out.store_en),
    .wr_idx  (s2_idx),
    .wr_data (ac),
    .rd_en   (adv1),
    .rd_idx  (s1_idx),
    .rd_data (rd_data)
  );

  assign mem_word = fwd_hit ? fwd_data : rd_data;

  acpu_alu u_alu (
    .instr    (s2_instr),
    .ac       (ac),
    .pc       (pc),
    .mem_word (mem_word),
    .alu_out  (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ac <= '0;
      pc <= '0;
    end else if (s2_fire) begin
      ac <= alu_out.acc_next;
      pc <= alu_out.pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (s2_fire) begin
      result <= alu_out.res;
    end
  end

  assign s2_pc_op = (s2_instr.opcode == OP_SKIP) || (s2_instr.opcode == OP_JUMP) ||
                    (s2_instr.opcode == OP_JZ) || (s2_instr.opcode == OP_JNZ) ||
                    (s2_instr.opcode == OP_PCDEC);

  `ACPU_ASSERT_NOW(a_stall_needs_item, instr_stall, s1_valid && s2_valid, "stall with free stage")
  `ACPU_ASSERT_NEXT(a_pc_holds, s2_fire && !s2_pc_op, pc == $past(pc), "PC moved on non-branch")
  `ACPU_ASSERT_NEXT(a_store_keeps_ac, s2_fire && (s2_instr.opcode == OP_STORE), ac == $past(ac) && result_valid, "store changed accumulator")
  `ACPU_ASSERT_NEXT(a_out_flag, s2_fire, result.out_valid == ($past(s2_instr.opcode) == OP_OUTPUT), "output flag mismatch")

endmodule

// ===== rtl/core/acpu_mem.sv =====
// Main memory of the execute core: one write port, one registered read port.
// Depends on acpu_pkg for the data width.
`timescale 1ns / 1ps

module acpu_mem #(
  parameter int DEPTH = acpu_pkg::MEM_DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(acpu_pkg::MEM_DEPTH_DEFAULT)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [acpu_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_idx,
  output logic [acpu_pkg::DATA_W-1:0] rd_data
);
  import acpu_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Read returns the old word when the same entry is written at the same edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

// ===== rtl/core/acpu_alu.sv =====
// Combinational execute logic: next accumulator, next PC and result fields.
// Depends on acpu_pkg for types and opcodes.
`timescale 1ns / 1ps

module acpu_alu (
  input  acpu_pkg::instr_t            instr,
  input  logic [acpu_pkg::DATA_W-1:0] ac,
  input  logic [acpu_pkg::ADDR_W-1:0] pc,
  input  logic [acpu_pkg::DATA_W-1:0] mem_word,
  output acpu_pkg::alu_out_t          alu_out
);
  import acpu_pkg::*;

  logic [DATA_W-1:0] ac_n;
  logic [ADDR_W-1:0] pc_n;
  logic              big_shift;
  logic              ac_zero;

  assign big_shift = (instr.shift_count >= SHAMT_W'(DATA_W));
  assign ac_zero   = (ac == '0);

  always_comb begin
    ac_n = ac;
    pc_n = pc;
    alu_out.store_en      = 1'b0;
    alu_out.res.out_valid = 1'b0;
    alu_out.res.out_word  = '0;
    case (instr.opcode)
      OP_ADD:    ac_n = ac + $unsigned(instr.data_value);
      OP_SUB:    ac_n = ac - $unsigned(instr.data_value);
      OP_STORE:  alu_out.store_en = 1'b1;
      OP_LOAD:   ac_n = mem_word;
      OP_INPUT:  ac_n = $unsigned(instr.data_value);
      OP_OUTPUT: begin
        alu_out.res.out_valid = 1'b1;
        alu_out.res.out_word  = $signed(ac);
      end
      OP_SKIP: begin
        // skip only on strictly positive
        if (!ac_zero && !ac[DATA_W-1]) begin
          pc_n = pc + ADDR_W'(1);
        end
      end
      OP_JUMP:   pc_n = instr.address;
      OP_SHR:    ac_n = big_shift ? '0 : (ac >> instr.shift_count[SH_IDX_W-1:0]);
      OP_SHL:    ac_n = big_shift ? '0 : (ac << instr.shift_count[SH_IDX_W-1:0]);
      OP_JZ: begin
        if (ac_zero) begin
          pc_n = instr.address;
        end
      end
      OP_JNZ: begin
        if (!ac_zero) begin
          pc_n = instr.address;
        end
      end
      OP_CLEAR:  ac_n = '0;
      OP_INVERT: ac_n = ~ac;
      OP_PCDEC:  pc_n = pc - ADDR_W'(2);
      default: begin
        ac_n = ac;
        pc_n = pc;
      end
    endcase
    alu_out.acc_next     = ac_n;
    alu_out.pc_next      = pc_n;
    alu_out.res.acc_value = $signed(ac_n);
    alu_out.res.pc_value  = pc_n;
  end

endmodule
